FILE: rtl/config_file_crc_checker_defines.svh
// ----------------------------------------------------------------------------
// config_file_crc_checker_defines.svh
// Assertion macros shared by the checker of the configuration file CRC block.
// ----------------------------------------------------------------------------
`ifndef CONFIG_FILE_CRC_CHECKER_DEFINES_SVH
`define CONFIG_FILE_CRC_CHECKER_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet while rst_n is low.
`define CRCC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and quiet while rst_n is low.
`define CRCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/crcc_pkg.sv
// ----------------------------------------------------------------------------
// crcc_pkg
// Types, constants and the table-entry function of the configuration file
// CRC checker.
// ----------------------------------------------------------------------------
`default_nettype none

package crcc_pkg;

  localparam int unsigned POS_W   = 17;
  localparam logic [POS_W-1:0] POS_MAX = 17'h1ffff;

  localparam logic [7:0]  HDR_BYTE0 = 8'h52;  // 'R'
  localparam logic [7:0]  HDR_BYTE1 = 8'h43;  // 'C'
  localparam logic [15:0] POLY_RESET = 16'h8005;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;

  typedef enum logic [1:0] {
    KIND_SKIP,
    KIND_DATA,
    KIND_CHK_HI,
    KIND_CHK_LO
  } byte_kind_t;

  // One classified byte on its way from the front end to the CRC engine.
  typedef struct packed {
    byte_kind_t  kind;
    logic [7:0]  data;
    logic        last;
    logic        hdr_ok;
    logic        len_bad;
    logic        size_ok;
    logic [15:0] decl_len;
  } q_entry_t;

  // Shifts a seed through sixteen steps of the generator polynomial.
  function automatic logic [15:0] table_seed(input logic [15:0] poly,
                                             input logic [15:0] seed);
    logic [15:0] c;
    logic        msb;
    c = seed;
    for (int s = 0; s < 16; s++) begin
      msb = c[15];
      c   = {c[14:0], 1'b0};
      if (msb) begin
        c = c ^ poly;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/crcc_fifo.sv
// ----------------------------------------------------------------------------
// crcc_fifo
// Two-entry queue of classified bytes between the front end and the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module crcc_fifo (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire crcc_pkg::q_entry_t push_entry,
  output logic                    full,
  input  wire logic               pop,
  output logic                    head_valid,
  output crcc_pkg::q_entry_t      head_entry
);

  crcc_pkg::q_entry_t                mem_r [crcc_pkg::QDEPTH];
  logic [crcc_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [crcc_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [crcc_pkg::QPTR_W:0]         count_r, count_nxt;
  logic                              do_push, do_pop;

  assign full       = (count_r == (crcc_pkg::QPTR_W+1)'(crcc_pkg::QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = mem_r[rd_ptr_r];

  assign do_push = push && !full;
  assign do_pop  = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/crcc_front.sv
// ----------------------------------------------------------------------------
// crcc_front
// Byte counter and classifier: checks the header, captures the length and
// tags each byte as data, stored check or filler for the CRC engine.
// ----------------------------------------------------------------------------
`default_nettype none

module crcc_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic [7:0]         in_data_byte,
  input  wire logic               in_last_byte,
  output logic                    in_stall,
  input  wire logic               q_full,
  output logic                    q_push,
  output crcc_pkg::q_entry_t      q_entry
);

  logic [crcc_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic                       hdr_good_r, hdr_good_nxt;
  logic [15:0]                len_r, len_nxt;
  logic [crcc_pkg::POS_W-1:0] pos_inc;
  logic [crcc_pkg::POS_W-1:0] data_end;
  logic                       accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;

  assign pos_inc  = (pos_r == crcc_pkg::POS_MAX) ? pos_r : pos_r + 1'b1;
  // Position of the high stored-check byte; data bytes sit below it.
  assign data_end = {1'b0, len_r} + crcc_pkg::POS_W'(2);

  always_comb begin
    hdr_good_nxt = hdr_good_r;
    len_nxt      = len_r;
    q_entry.kind = crcc_pkg::KIND_SKIP;

    if (pos_r == crcc_pkg::POS_W'(0)) begin
      hdr_good_nxt = hdr_good_r && (in_data_byte == crcc_pkg::HDR_BYTE0);
    end else if (pos_r == crcc_pkg::POS_W'(1)) begin
      hdr_good_nxt = hdr_good_r && (in_data_byte == crcc_pkg::HDR_BYTE1);
    end else if (pos_r == crcc_pkg::POS_W'(2)) begin
      len_nxt = {in_data_byte, 8'h00};
    end else if (pos_r == crcc_pkg::POS_W'(3)) begin
      len_nxt = {len_r[15:8], in_data_byte};
    end else if (len_r >= 16'd2) begin
      if (pos_r < data_end) begin
        q_entry.kind = crcc_pkg::KIND_DATA;
      end else if (pos_r == data_end) begin
        q_entry.kind = crcc_pkg::KIND_CHK_HI;
      end else if (pos_r == data_end + 1'b1) begin
        q_entry.kind = crcc_pkg::KIND_CHK_LO;
      end
    end

    q_entry.data     = in_data_byte;
    q_entry.last     = in_last_byte;
    q_entry.hdr_ok   = hdr_good_nxt && (pos_inc >= crcc_pkg::POS_W'(2));
    q_entry.len_bad  = (pos_inc < crcc_pkg::POS_W'(4)) || (len_nxt < 16'd2);
    q_entry.size_ok  = (pos_inc == {1'b0, len_nxt} + crcc_pkg::POS_W'(4));
    q_entry.decl_len = len_nxt;

    pos_nxt = pos_inc;
    // The file ends here, so the next byte opens a new one.
    if (in_last_byte) begin
      pos_nxt      = '0;
      hdr_good_nxt = 1'b1;
      len_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      hdr_good_r <= 1'b1;
      len_r      <= '0;
    end else if (accept) begin
      pos_r      <= pos_nxt;
      hdr_good_r <= hdr_good_nxt;
      len_r      <= len_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/crcc_back.sv
// ----------------------------------------------------------------------------
// crcc_back
// CRC engine: runs the table-style update on data bytes, captures the stored
// check and loads the result register on the last byte of a file.
// ----------------------------------------------------------------------------
`default_nettype none

module crcc_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [15:0]        cfg_wdata,
  input  wire logic               head_valid,
  input  wire crcc_pkg::q_entry_t head_entry,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_header_ok,
  output logic                    out_length_bad,
  output logic                    out_size_ok,
  output logic [15:0]             out_declared_length,
  output logic [15:0]             out_stored_check,
  output logic [15:0]             out_computed_check,
  output logic                    out_check_match
);

  logic [15:0]       poly_r, poly_nxt;
  logic [7:0][15:0]  basis_r, basis_nxt;
  logic [15:0]       run_r, run_nxt;
  logic [15:0]       cap_r, cap_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_load;
  logic [7:0]        tbl_idx;
  logic [15:0]       tbl_val;

  logic              hdr_ok_r, len_bad_r, size_ok_r, match_r;
  logic [15:0]       decl_len_r, stored_r, computed_r;

  // The basis is registered from the next polynomial, so it changes with the
  // polynomial register and a byte taken after a write sees the new generator.
  always_comb begin
    poly_nxt = poly_r;
    if (!rst_n) begin
      poly_nxt = crcc_pkg::POLY_RESET;
    end else if (cfg_we) begin
      poly_nxt = cfg_wdata;
    end
  end

  // The table is linear in its index, so one entry is the XOR of the
  // entries for the single set bits, which only change with the polynomial.
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      basis_nxt[k] = crcc_pkg::table_seed(poly_nxt, 16'(1) << k);
    end
  end

  assign tbl_idx = run_r[7:0] ^ head_entry.data;

  always_comb begin
    tbl_val = '0;
    for (int k = 0; k < 8; k++) begin
      if (tbl_idx[k]) begin
        tbl_val = tbl_val ^ basis_r[k];
      end
    end
  end

  assign out_load = !out_valid_r || !out_stall;
  assign pop      = head_valid && (!head_entry.last || out_load);

  always_comb begin
    run_nxt = run_r;
    cap_nxt = cap_r;
    case (head_entry.kind)
      crcc_pkg::KIND_DATA:   run_nxt = {run_r[15:8], 8'h00} ^ tbl_val;
      crcc_pkg::KIND_CHK_HI: cap_nxt = {head_entry.data, cap_r[7:0]};
      crcc_pkg::KIND_CHK_LO: cap_nxt = {cap_r[15:8], head_entry.data};
      default: ;
    endcase

    out_valid_nxt = out_valid_r && out_stall;
    if (pop && head_entry.last) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r      <= crcc_pkg::POLY_RESET;
      run_r       <= '0;
      cap_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      poly_r <= poly_nxt;
      if (pop) begin
        run_r <= head_entry.last ? 16'h0000 : run_nxt;
        cap_r <= head_entry.last ? 16'h0000 : cap_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    basis_r <= basis_nxt;
    if (pop && head_entry.last) begin
      hdr_ok_r   <= head_entry.hdr_ok;
      len_bad_r  <= head_entry.len_bad;
      size_ok_r  <= head_entry.size_ok;
      decl_len_r <= head_entry.decl_len;
      stored_r   <= cap_nxt;
      computed_r <= run_nxt;
      match_r    <= !head_entry.len_bad && (cap_nxt == run_nxt);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_header_ok       = hdr_ok_r;
  assign out_length_bad      = len_bad_r;
  assign out_size_ok         = size_ok_r;
  assign out_declared_length = decl_len_r;
  assign out_stored_check    = stored_r;
  assign out_computed_check  = computed_r;
  assign out_check_match     = match_r;

endmodule

`default_nettype wire

FILE: rtl/config_file_crc_checker.sv
// ----------------------------------------------------------------------------
// config_file_crc_checker
// Takes one byte per cycle unless in_stall is high; the engine's CRC update
// loop sets that rate. A file's result is registered when its last byte
// leaves the queue. Synchronous active-low reset empties the queue, clears
// counters and the result valid, and restores the polynomial to 0x8005.
// ----------------------------------------------------------------------------
`default_nettype none

module config_file_crc_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_header_ok,
  output logic             out_length_bad,
  output logic             out_size_ok,
  output logic [15:0]      out_declared_length,
  output logic [15:0]      out_stored_check,
  output logic [15:0]      out_computed_check,
  output logic             out_check_match
);

  logic               q_full;
  logic               q_push;
  crcc_pkg::q_entry_t q_entry;
  logic               q_pop;
  logic               q_head_valid;
  crcc_pkg::q_entry_t q_head;

  crcc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .in_stall     (in_stall),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (q_entry)
  );

  crcc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_entry (q_head)
  );

  crcc_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .head_valid          (q_head_valid),
    .head_entry          (q_head),
    .pop                 (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_header_ok       (out_header_ok),
    .out_length_bad      (out_length_bad),
    .out_size_ok         (out_size_ok),
    .out_declared_length (out_declared_length),
    .out_stored_check    (out_stored_check),
    .out_computed_check  (out_computed_check),
    .out_check_match     (out_check_match)
  );

endmodule

`default_nettype wire

FILE: rtl/crcc_checker.sv
// ----------------------------------------------------------------------------
// crcc_checker
// Port-level checks on the results of the configuration file CRC checker.
// ----------------------------------------------------------------------------
`default_nettype none
`include "config_file_crc_checker_defines.svh"

module crcc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_header_ok,
  input wire logic        out_length_bad,
  input wire logic        out_size_ok,
  input wire logic [15:0] out_declared_length,
  input wire logic [15:0] out_stored_check,
  input wire logic [15:0] out_computed_check,
  input wire logic        out_check_match
);

  // A stalled result must stay offered with checks, match, header_ok stable.
  `CRCC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_computed_check) && $stable(out_stored_check) && $stable(out_check_match) && $stable(out_header_ok), "result changed while stalled")

  `CRCC_ASSERT_IMP(a_match_consistent, out_valid && out_check_match, !out_length_bad && (out_stored_check == out_computed_check), "match flag disagrees with checks")

  // With a length below two no byte reaches the CRC or the stored check.
  `CRCC_ASSERT_IMP(a_short_length, out_valid && (out_declared_length < 16'd2), out_length_bad && (out_stored_check == 16'h0000) && (out_computed_check == 16'h0000), "short length left checks set")

  // A matching size with a sane length implies the four header bytes arrived.
  `CRCC_ASSERT_IMP(a_size_implies_length, out_valid && out_size_ok && (out_declared_length >= 16'd2), !out_length_bad, "size ok but length flagged bad")

endmodule

bind config_file_crc_checker crcc_checker u_crcc_checker (.*);

`default_nettype wire

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for config_file_crc_checker
// Streams configuration files byte by byte under several polynomials. A
// scoreboard predicts each file verdict and checks it against the block.
// The files cover headers, length fields, stored checks and trailing bytes.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    bit        header_ok;
    bit        length_bad;
    bit        size_ok;
    bit [15:0] declared_length;
    bit [15:0] stored_check;
    bit [15:0] computed_check;
    bit        check_match;
  } file_verdict_t;

  class file_scoreboard;
    bit [15:0]     poly;
    bit [16:0]     pos;
    bit            hdr_good;
    bit [15:0]     len_field;
    bit [15:0]     run_crc;
    bit [15:0]     cap_crc;
    file_verdict_t expected_verdicts[$];
    int            mismatches;
    int            verdicts_checked;

    function new();
      poly = crcc_pkg::POLY_RESET;
      clear_file();
    endfunction

    function void clear_file();
      pos      = '0;
      hdr_good = 1'b1;
      len_field = '0;
      run_crc  = '0;
      cap_crc  = '0;
    endfunction

    // The table entry is the index pushed through sixteen shift steps.
    function bit [15:0] crc_step(bit [15:0] crc, bit [7:0] b);
      bit [15:0] r;
      bit        top;
      r = {8'h00, crc[7:0] ^ b};
      for (int s = 0; s < 16; s++) begin
        top = r[15];
        r   = {r[14:0], 1'b0};
        if (top) r = r ^ poly;
      end
      return (crc & 16'hff00) ^ r;
    endfunction

    function void note_byte(bit [7:0] b, bit last);
      bit [16:0]     d;
      bit [16:0]     dlen;
      file_verdict_t v;
      d    = pos - 17'd4;
      dlen = {1'b0, len_field} - 17'd2;
      case (pos)
        17'd0: if (b != crcc_pkg::HDR_BYTE0) hdr_good = 1'b0;
        17'd1: if (b != crcc_pkg::HDR_BYTE1) hdr_good = 1'b0;
        17'd2: len_field = {b, 8'h00};
        17'd3: len_field[7:0] = b;
        default: begin
          if (len_field >= 16'd2) begin
            if (d < dlen) run_crc = crc_step(run_crc, b);
            else if (d == dlen) cap_crc[15:8] = b;
            else if (d == dlen + 17'd1) cap_crc[7:0] = b;
          end
        end
      endcase
      if (pos != crcc_pkg::POS_MAX) pos++;
      if (last) begin
        v.header_ok       = hdr_good && pos >= 17'd2;
        v.length_bad      = pos < 17'd4 || len_field < 16'd2;
        v.size_ok         = pos == 17'd4 + {1'b0, len_field};
        v.declared_length = len_field;
        v.stored_check    = cap_crc;
        v.computed_check  = run_crc;
        v.check_match     = !v.length_bad && cap_crc == run_crc;
        expected_verdicts.push_back(v);
        clear_file();
      end
    endfunction

    task report_mismatch(string what);
      $display("ERROR at %0t: %s", $time, what);
      mismatches++;
    endtask

    task compare_field(string name, bit [15:0] got, bit [15:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
    endtask

    task check_verdict(file_verdict_t got);
      file_verdict_t want;
      if (expected_verdicts.size() == 0) begin
        report_mismatch("verdict transaction with no file outstanding");
      end else begin
        want = expected_verdicts.pop_front();
        compare_field("header_ok", got.header_ok, want.header_ok);
        compare_field("length_bad", got.length_bad, want.length_bad);
        compare_field("size_ok", got.size_ok, want.size_ok);
        compare_field("declared_length", got.declared_length, want.declared_length);
        compare_field("stored_check", got.stored_check, want.stored_check);
        compare_field("computed_check", got.computed_check, want.computed_check);
        compare_field("check_match", got.check_match, want.check_match);
        verdicts_checked++;
      end
    endtask
  endclass

  localparam int PHASE_BYTES = 370;
  localparam int HOLD_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_stall;
  logic        out_header_ok;
  logic        out_length_bad;
  logic        out_size_ok;
  logic [15:0] out_declared_length;
  logic [15:0] out_stored_check;
  logic [15:0] out_computed_check;
  logic        out_check_match;

  file_scoreboard sb;
  file_verdict_t  observed;
  bit [7:0]       file_bytes[$];
  bit             quiet = 1'b0;
  int             hold_left = 0;
  int             bytes_sent = 0;
  int             settings_used = 1;

  assign observed = {out_header_ok, out_length_bad, out_size_ok, out_declared_length,
                     out_stored_check, out_computed_check, out_check_match};

  always #1 clk = ~clk;

  config_file_crc_checker i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_data_byte        (in_data_byte),
    .in_last_byte        (in_last_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_header_ok       (out_header_ok),
    .out_length_bad      (out_length_bad),
    .out_size_ok         (out_size_ok),
    .out_declared_length (out_declared_length),
    .out_stored_check    (out_stored_check),
    .out_computed_check  (out_computed_check),
    .out_check_match     (out_check_match)
  );

  // Receiver side: random stalls, or a counted hold-off when one is requested.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 9);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_verdict(observed);
  end

  // Called at a rising edge; returns at the edge where the byte was taken.
  task send_byte(bit [7:0] b, bit last);
    while (!quiet && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b, last);
    bytes_sent++;
  endtask

  task send_file();
    for (int i = 0; i < file_bytes.size(); i++) send_byte(file_bytes[i], i == file_bytes.size() - 1);
  endtask

  // Appends the check over everything after the length field.
  task append_check();
    bit [15:0] crc;
    crc = '0;
    for (int i = 4; i < file_bytes.size(); i++) crc = sb.crc_step(crc, file_bytes[i]);
    file_bytes.push_back(crc[15:8]);
    file_bytes.push_back(crc[7:0]);
  endtask

  task build_random_file();
    int pick;
    int len;
    int cut;
    pick = $urandom_range(99);
    len  = ($urandom_range(19) == 0) ? $urandom_range(2, 300) : $urandom_range(2, 20);
    file_bytes.delete();
    if (pick < 6) begin
      repeat ($urandom_range(1, 8)) file_bytes.push_back(8'($urandom));
    end else begin
      // A random length field rarely matches the body, so these files end early.
      if (pick < 10) len = $urandom_range(65535);
      file_bytes = {crcc_pkg::HDR_BYTE0, crcc_pkg::HDR_BYTE1, 8'(len >> 8), 8'(len)};
      for (int i = 0; i < len - 2 && i < 400; i++) begin
        if ($urandom_range(9) == 0) file_bytes.push_back($urandom_range(1) ? 8'hff : 8'h00);
        else file_bytes.push_back(8'($urandom));
      end
      append_check();
      if (pick >= 80 && pick < 86) begin
        file_bytes[file_bytes.size() - 1 - $urandom_range(1)] ^= 8'(1 << $urandom_range(7));
      end else if (pick >= 86 && pick < 90) begin
        file_bytes[$urandom_range(1)] ^= 8'($urandom_range(1, 255));
      end else if (pick >= 90 && pick < 95) begin
        repeat ($urandom_range(1, 4)) file_bytes.push_back(8'($urandom));
      end else if (pick >= 95 || pick < 10) begin
        cut = $urandom_range(1, file_bytes.size());
        while (file_bytes.size() > cut) void'(file_bytes.pop_back());
      end
    end
  endtask

  task run_random_phase();
    int start;
    start = bytes_sent;
    while (bytes_sent - start < PHASE_BYTES) begin
      build_random_file();
      send_file();
    end
    in_valid <= 1'b0;
  endtask

  // The register may only change once every file has been reported.
  task write_polynomial(bit [15:0] value);
    while (sb.expected_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.poly = value;
    settings_used++;
  endtask

  initial begin
    sb = new();
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    in_valid     <= 1'b0;
    in_data_byte <= '0;
    in_last_byte <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed files: lone first byte, short file, no data at all, missing
    // stored check, extremes of the data and bytes past the stored check.
    file_bytes = {crcc_pkg::HDR_BYTE0};
    send_file();
    file_bytes = {8'h58, crcc_pkg::HDR_BYTE1, 8'h80};
    send_file();
    file_bytes = {crcc_pkg::HDR_BYTE0, crcc_pkg::HDR_BYTE1, 8'h00, 8'h00, 8'h07};
    send_file();
    file_bytes = {crcc_pkg::HDR_BYTE0, crcc_pkg::HDR_BYTE1, 8'h00, 8'h02, 8'h00, 8'h00};
    send_file();
    file_bytes = {crcc_pkg::HDR_BYTE0, crcc_pkg::HDR_BYTE1, 8'h00, 8'h04, 8'h00, 8'hff};
    append_check();
    file_bytes.push_back(8'ha5);
    send_file();
    file_bytes = {crcc_pkg::HDR_BYTE0, 8'h44, 8'h00, 8'h05, 8'h11, 8'h22, 8'h33};
    send_file();

    run_random_phase();

    write_polynomial(16'h0000);
    quiet = 1'b1;
    run_random_phase();
    quiet = 1'b0;

    write_polynomial(16'hffff);
    run_random_phase();

    // The sender keeps offering while the result side holds off.
    write_polynomial(16'h1021);
    hold_left = HOLD_CYCLES;
    run_random_phase();

    write_polynomial(16'($urandom));
    run_random_phase();

    while (sb.expected_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Checked %0d file verdicts over %0d bytes under %0d polynomial settings.",
             sb.verdicts_checked, bytes_sent, settings_used);
    $display("Files were short, malformed, well formed and padded; output held off %0d cycles.",
             HOLD_CYCLES);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
